// File: rtl/grrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grrt_pkg: shared types and constants of the guest region range table
// Holds the table geometry, the request and response codes, the transfer
// payload structs and the control struct between sequencer and datapath.
// ----------------------------------------------------------------------------
package grrt_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int ADDR_W      = 64;
	localparam int ENTRY_W     = 2 * ADDR_W;

	// request kinds (any other code is a lookup)
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;

	// response status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERLAP   = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] length;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [3:0]        entry_index;
		logic [ADDR_W-1:0] entry_base;
		logic [ADDR_W-1:0] entry_length;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPEND,
		S_RESP
	} state_t;

	typedef struct packed {
		logic             ld_item;
		logic             ram_re;
		logic [IDX_W-1:0] ram_raddr;
		logic             ram_we;
		logic [IDX_W-1:0] ram_waddr;
		logic             res_ld;
		logic [1:0]       res_status;
		logic [IDX_W-1:0] res_idx;
		logic             res_take_entry;
	} seq_ctl_t;

	// low four bits of a table index, zero extended when the index is narrower
	function automatic logic [3:0] to_entry_index(input logic [IDX_W-1:0] idx);
		logic [IDX_W+3:0] t;
		t = {4'b0000, idx};
		return t[3:0];
	endfunction

endpackage

// File: rtl/guest_region_range_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guest_region_range_table: guest memory region table
// Stores up to MAX_REGIONS base and size pairs in insertion order, appends
// with or without an overlap check and looks up the region holding an
// address.
// ----------------------------------------------------------------------------
// usage
//  - request channel req_valid / req_stall carries kind, address and length;
//    req_stall is high from the transfer until the response has been taken,
//    so one request is in the block at a time
//  - response channel rsp_valid / rsp_stall carries status, entry index,
//    base and length; the response is held in a register until its transfer
//  - an add goes from the request transfer through the append state to the
//    response state; insert and lookup first scan the stored regions (an
//    insert without overlap then appends), ending early on a hit; the region
//    scan reads one table entry per cycle through the single RAM read port
//    and the shared compare unit sets the pace
//  - a new request is taken only once the previous response has transferred
//  - reset empties the table at once (count only, no clearing pass); entry
//    contents are never read before they are written
//  - a stalled response holds its value and blocks new requests
// ----------------------------------------------------------------------------
module guest_region_range_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  grrt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output grrt_pkg::rsp_t  rsp
);
	import grrt_pkg::*;

	seq_ctl_t          ctl;
	logic              busy;
	logic              overlap_mode;
	logic              hit;
	logic [ADDR_W-1:0] probe_q;
	logic [ADDR_W-1:0] length_q;
	logic [ADDR_W-1:0] new_end_q;
	logic [ENTRY_W-1:0] rd_entry;
	rsp_t              rsp_q;

	// no transfer while a request is being worked on or its response waits
	assign req_stall = busy;

	// request fields captured at the transfer; new range end wraps mod 2^64
	always_ff @(posedge clk) begin
		if (ctl.ld_item) begin
			probe_q   <= req.address;
			length_q  <= req.length;
			new_end_q <= req.address + req.length;
		end
	end

	// region storage, base in the upper half, size in the lower half
	grrt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_REGIONS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.ram_we),
		.waddr (ctl.ram_waddr),
		.wdata ({probe_q, length_q}),
		.re    (ctl.ram_re),
		.raddr (ctl.ram_raddr),
		.rdata (rd_entry)
	);

	// one compare per cycle on the entry just read
	grrt_cmp u_cmp (
		.ent_base     (rd_entry[ENTRY_W-1:ADDR_W]),
		.ent_length   (rd_entry[ADDR_W-1:0]),
		.probe        (probe_q),
		.new_end      (new_end_q),
		.overlap_mode (overlap_mode),
		.hit          (hit)
	);

	grrt_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_kind     (req.kind),
		.rsp_stall    (rsp_stall),
		.hit          (hit),
		.busy         (busy),
		.overlap_mode (overlap_mode),
		.rsp_valid    (rsp_valid),
		.ctl          (ctl)
	);

	// response register, base and size only on a lookup hit
	always_ff @(posedge clk) begin
		if (ctl.res_ld) begin
			rsp_q.status      <= ctl.res_status;
			rsp_q.entry_index <= to_entry_index(ctl.res_idx);
			if (ctl.res_take_entry) begin
				rsp_q.entry_base   <= rd_entry[ENTRY_W-1:ADDR_W];
				rsp_q.entry_length <= rd_entry[ADDR_W-1:0];
			end else begin
				rsp_q.entry_base   <= '0;
				rsp_q.entry_length <= '0;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// File: rtl/grrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grrt_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module grrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/grrt_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grrt_cmp: shared range compare unit
// Forms the end of one stored region and tests it either for overlap with
// the new range or for holding the probed address.
// ----------------------------------------------------------------------------
module grrt_cmp (
	input  logic [grrt_pkg::ADDR_W-1:0] ent_base,
	input  logic [grrt_pkg::ADDR_W-1:0] ent_length,
	input  logic [grrt_pkg::ADDR_W-1:0] probe,
	input  logic [grrt_pkg::ADDR_W-1:0] new_end,
	input  logic                        overlap_mode,
	output logic                        hit
);
	import grrt_pkg::*;

	logic [ADDR_W-1:0] ent_end;
	logic              meet;
	logic              holds;

	// ends wrap modulo 2^64
	assign ent_end = ent_base + ent_length;
	assign meet    = !((ent_end <= probe) || (ent_base >= new_end));
	assign holds   = (ent_base <= probe) && (probe < ent_end);
	assign hit     = overlap_mode ? meet : holds;

endmodule

// File: rtl/grrt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grrt_seq: request sequencer
// Walks the stored regions one per cycle through the compare unit, appends
// new regions, keeps the region count and forms the response code.
// ----------------------------------------------------------------------------
module grrt_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          req_kind,
	input  logic                rsp_stall,
	input  logic                hit,
	output logic                busy,
	output logic                overlap_mode,
	output logic                rsp_valid,
	output grrt_pkg::seq_ctl_t  ctl
);
	import grrt_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic             is_insert_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pidx_s1;
	logic             issue;
	logic             found;
	logic             full;

	assign issue        = scan_q < count_q;
	assign found        = pend_s1 && hit;
	assign full         = count_q == CNT_W'(MAX_REGIONS);
	assign overlap_mode = is_insert_q;
	assign busy         = state_q != S_IDLE;
	assign rsp_valid    = state_q == S_RESP;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req_kind == KIND_ADD) ? S_APPEND : S_SCAN;
				end
			end
			S_SCAN: begin
				if (found) begin
					state_d = S_RESP;
				end else if (!issue) begin
					state_d = is_insert_q ? S_APPEND : S_RESP;
				end
			end
			S_APPEND: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl                = '0;
		ctl.ram_raddr      = scan_q[IDX_W-1:0];
		ctl.ram_waddr      = count_q[IDX_W-1:0];
		ctl.res_status     = ST_OK;
		case (state_q)
			S_IDLE: begin
				ctl.ld_item = req_valid;
			end
			S_SCAN: begin
				ctl.ram_re = issue && !found;
				if (found) begin
					ctl.res_ld = 1'b1;
					if (is_insert_q) begin
						ctl.res_status = ST_OVERLAP;
					end else begin
						ctl.res_status     = ST_OK;
						ctl.res_idx        = pidx_s1;
						ctl.res_take_entry = 1'b1;
					end
				end else if (!issue && !is_insert_q) begin
					ctl.res_ld     = 1'b1;
					ctl.res_status = ST_NOT_FOUND;
				end
			end
			S_APPEND: begin
				ctl.res_ld = 1'b1;
				if (full) begin
					ctl.res_status = ST_FULL;
				end else begin
					ctl.ram_we     = 1'b1;
					ctl.res_status = ST_OK;
					ctl.res_idx    = count_q[IDX_W-1:0];
				end
			end
			S_RESP: begin
				ctl.res_ld = 1'b0;
			end
			default: begin
				ctl.res_ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			is_insert_q <= 1'b0;
			count_q     <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			pidx_s1     <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= ctl.ram_re;
			pidx_s1 <= scan_q[IDX_W-1:0];
			if (ctl.ld_item) begin
				is_insert_q <= req_kind == KIND_INSERT;
				scan_q      <= '0;
			end else if (ctl.ram_re) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (ctl.ram_we) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REGIONS))
		else $error("region count above table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ram_we |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not advance region count");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_item |=> busy)
		else $error("sequencer idle after accepting a request");

	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> state_q == S_SCAN)
		else $error("read in flight outside a scan");

endmodule

// File: sim/tb_guest_region_range_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_guest_region_range_table: self-checking bench for the guest region table
// Feeds add, checked insert and lookup requests through the valid / stall
// channels with random gaps on both sides, computes each response from a
// local copy of the region table and checks every response field in order.
// ----------------------------------------------------------------------------
module tb_guest_region_range_table;
	import grrt_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT  = 400000;   // watchdog limit on the whole run
	localparam int HOLD_AT      = 150;      // responses seen before the long hold
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_AT     = 700;      // request count at which the sender drains
	localparam int SETTLE       = 40;       // wait after the drain for a late or extra response
	localparam int MAX_SHOWN    = 10;

	// lookup codes, the spare code is answered as a lookup
	localparam logic [1:0] KIND_LOOKUP = 2'd2;
	localparam logic [1:0] KIND_SPARE  = 2'd3;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	guest_region_range_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// requests waiting to be offered and responses waiting to arrive
	req_t pending_reqs[$];
	rsp_t awaited_rsp[$];

	// regions handed to the generator, used to aim probes at range edges
	logic [63:0] plan_base[$];
	logic [63:0] plan_len[$];

	// local copy of the region table
	logic [63:0]      tbl_base [MAX_REGIONS];
	logic [63:0]      tbl_len  [MAX_REGIONS];
	logic [CNT_W-1:0] tbl_count = '0;

	int total_reqs = 0;
	int reqs_sent  = 0;
	int rsps_seen  = 0;
	int mismatches = 0;
	int cycles     = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	int status_seen [4] = '{0, 0, 0, 0};

	// next response of the table for one transferred request, table updated
	function automatic rsp_t answer_request(input req_t r);
		rsp_t        a;
		logic [63:0] end_new;
		logic [63:0] end_old;
		bit          overlap;
		bit          found;
		a       = '0;
		overlap = 1'b0;
		found   = 1'b0;
		if (r.kind == KIND_INSERT) begin
			// ends wrap modulo 2^64, zero-size ranges follow the same test
			end_new = r.address + r.length;
			for (int i = 0; i < tbl_count; i++) begin
				end_old = tbl_base[i] + tbl_len[i];
				if (!(end_old <= r.address || tbl_base[i] >= end_new))
					overlap = 1'b1;
			end
		end
		if (r.kind == KIND_ADD || r.kind == KIND_INSERT) begin
			// overlap wins over a full table
			if (overlap) begin
				a.status = ST_OVERLAP;
			end else if (tbl_count >= MAX_REGIONS) begin
				a.status = ST_FULL;
			end else begin
				tbl_base[tbl_count] = r.address;
				tbl_len[tbl_count]  = r.length;
				a.status            = ST_OK;
				a.entry_index       = tbl_count[3:0];
				tbl_count           = tbl_count + 1'b1;
			end
		end else begin
			// first region in insertion order that holds the address
			a.status = ST_NOT_FOUND;
			for (int i = 0; i < tbl_count; i++) begin
				end_old = tbl_base[i] + tbl_len[i];
				if (!found && tbl_base[i] <= r.address && r.address < end_old) begin
					found          = 1'b1;
					a.status       = ST_OK;
					a.entry_index  = i[3:0];
					a.entry_base   = tbl_base[i];
					a.entry_length = tbl_len[i];
				end
			end
		end
		return a;
	endfunction

	task automatic queue_req(input logic [1:0] kind, input logic [63:0] addr,
			input logic [63:0] len);
		req_t r;
		r.kind    = kind;
		r.address = addr;
		r.length  = len;
		pending_reqs.push_back(r);
		if (kind == KIND_ADD || kind == KIND_INSERT) begin
			plan_base.push_back(addr);
			plan_len.push_back(len);
		end
	endtask

	// request driver: offers the next pending request, holds it while stalled
	always @(posedge clk) begin : req_driver
		bit launch;
		int gap_pct;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				awaited_rsp.push_back(answer_request(req));
				reqs_sent++;
			end
			// payload may change only when nothing is offered or it just moved
			if (!req_valid || !req_stall) begin
				if (reqs_sent < total_reqs / 3)
					gap_pct = 30;
				else if (reqs_sent < 2 * total_reqs / 3)
					gap_pct = 65;
				else
					gap_pct = 0;
				launch = pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct;
				// one pause until the block has answered everything
				if (reqs_sent == DRAIN_AT && awaited_rsp.size() != 0)
					launch = 1'b0;
				if (launch) begin
					req       <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor: checks each transfer against the oldest expectation
	always @(posedge clk) begin : rsp_monitor
		rsp_t want;
		int   stall_pct;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsps_seen++;
				if (awaited_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("response %0d with none expected: status %0d index %0d base %h length %h",
							rsps_seen, rsp.status, rsp.entry_index, rsp.entry_base,
							rsp.entry_length);
				end else begin
					want = awaited_rsp.pop_front();
					status_seen[want.status]++;
					if (rsp.status !== want.status || rsp.entry_index !== want.entry_index ||
							rsp.entry_base !== want.entry_base ||
							rsp.entry_length !== want.entry_length) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("response %0d: expected status %0d index %0d base %h length %h, got status %0d index %0d base %h length %h",
								rsps_seen, want.status, want.entry_index, want.entry_base,
								want.entry_length, rsp.status, rsp.entry_index,
								rsp.entry_base, rsp.entry_length);
					end
				end
			end
			if (rsps_seen < total_reqs / 3)
				stall_pct = 65;
			else if (rsps_seen < 2 * total_reqs / 3)
				stall_pct = 30;
			else
				stall_pct = 0;
			// one long hold-off so the block backs up into the request side
			if (rsps_seen == HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d requests sent, %0d responses awaited",
				cycles, reqs_sent, total_reqs, awaited_rsp.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		int          sel;
		int          j;
		logic [1:0]  kind;
		logic [63:0] addr;
		logic [63:0] len;
		logic [63:0] b;
		logic [63:0] l;

		// empty table, both lookup codes
		queue_req(KIND_LOOKUP, 64'h0, 64'h0);
		queue_req(KIND_SPARE, ~64'h0, ~64'h0);
		// two unchecked adds that overlap each other
		queue_req(KIND_ADD, 64'h1000, 64'h100);
		queue_req(KIND_ADD, 64'h1080, 64'h100);
		// range edges and first match in insertion order
		queue_req(KIND_LOOKUP, 64'h1000, 64'h0);
		queue_req(KIND_LOOKUP, 64'h10ff, 64'h0);
		queue_req(KIND_LOOKUP, 64'h1100, 64'h0);
		queue_req(KIND_LOOKUP, 64'h1090, 64'h0);
		queue_req(KIND_LOOKUP, 64'h1180, 64'h0);
		queue_req(KIND_LOOKUP, 64'h0fff, 64'h0);
		// checked inserts: overlap, touching above, touching below
		queue_req(KIND_INSERT, 64'h1050, 64'h10);
		queue_req(KIND_INSERT, 64'h1180, 64'h80);
		queue_req(KIND_INSERT, 64'h0f00, 64'h100);
		// zero-size inserts inside and outside a stored range
		queue_req(KIND_INSERT, 64'h1040, 64'h0);
		queue_req(KIND_INSERT, 64'h5000, 64'h0);
		queue_req(KIND_LOOKUP, 64'h5000, 64'h0);
		// range that wraps past the top of the address space
		queue_req(KIND_ADD, 64'hffff_ffff_ffff_ff00, 64'h200);
		queue_req(KIND_LOOKUP, ~64'h0, 64'h0);
		queue_req(KIND_LOOKUP, 64'h0, 64'h0);
		// largest base and size, then a range covering almost everything
		queue_req(KIND_INSERT, ~64'h0, ~64'h0);
		queue_req(KIND_INSERT, 64'h0, ~64'h0);
		queue_req(KIND_SPARE, 64'h10a0, 64'h5a5a_5a5a_5a5a_5a5a);
		queue_req(KIND_ADD, 64'h0, 64'h0);

		// random part: mostly lookups aimed at stored range edges
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 3)
				kind = KIND_ADD;
			else if (sel < 12)
				kind = KIND_INSERT;
			else if (sel < 90)
				kind = KIND_LOOKUP;
			else
				kind = KIND_SPARE;
			j = $urandom_range(0, plan_base.size() - 1);
			b = plan_base[j];
			l = plan_len[j];
			if (kind == KIND_ADD || kind == KIND_INSERT) begin
				case ($urandom_range(0, 3))
					0: addr = {$urandom, $urandom};
					1: addr = b + $urandom_range(0, 'h1fff) - 64'h1000;
					2: addr = $urandom_range(0, 'hffff);
					default: addr = ~64'h0 - $urandom_range(0, 'hffff);
				endcase
				case ($urandom_range(0, 9))
					0: len = 64'h0;
					1: len = {$urandom, $urandom};
					2: len = ~64'h0 - $urandom_range(0, 3);
					default: len = $urandom_range(1, 'h1000);
				endcase
			end else begin
				len = {$urandom, $urandom};
				if ($urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 4))
						0: addr = b;
						1: addr = b - 1;
						2: addr = b + l - 1;
						3: addr = b + l;
						default: addr = b + (l >> $urandom_range(1, 63));
					endcase
				end else begin
					case ($urandom_range(0, 3))
						0: addr = 64'h0;
						1: addr = ~64'h0;
						default: addr = {$urandom, $urandom};
					endcase
				end
			end
			queue_req(kind, addr, len);
		end
		total_reqs = pending_reqs.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (reqs_sent != total_reqs || awaited_rsp.size() != 0)
			@(posedge clk);
		// room for a late or extra response to show up
		repeat (SETTLE) @(posedge clk);

		$display("%0d requests and %0d responses over %0d cycles, %0d regions stored",
			reqs_sent, rsps_seen, cycles, tbl_count);
		$display("responses by status: ok %0d, overlap %0d, full %0d, not found %0d",
			status_seen[ST_OK], status_seen[ST_OVERLAP], status_seen[ST_FULL],
			status_seen[ST_NOT_FOUND]);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/grrt_pkg.sv
rtl/grrt_ram.sv
rtl/grrt_cmp.sv
rtl/grrt_seq.sv
rtl/guest_region_range_table.sv
sim/tb_guest_region_range_table.sv
